FILE: sv/vnf_pkg.sv
// ----------------------------------------------------------------------------
// vnf_pkg: shared types and constants for the value-noise fBm density core
// Hash constants, fixed-point widths, register codes and remap constants.
// ----------------------------------------------------------------------------
package vnf_pkg;

   localparam int COORD_W   = 32;
   localparam int FREQ_IN_W = 24;
   localparam int AMP_W     = 18;
   localparam int CONTRIB_W = 20;
   localparam int SUM_W     = 24;
   localparam int RAW_W     = 20;
   localparam int DENS_W    = 17;

   typedef logic signed [COORD_W-1:0]   coord_type;
   typedef logic [31:0]                 word_type;
   typedef logic signed [31:0]          lattice_type;
   typedef logic signed [CONTRIB_W-1:0] contrib_type;
   typedef logic signed [SUM_W-1:0]     sum_type;

   // register codes (address bit 2)
   localparam logic REG_FREQ = 1'b0;
   localparam logic REG_AMP  = 1'b1;

   localparam logic [FREQ_IN_W-1:0] FREQ_RESET = 24'd65536;
   localparam logic [AMP_W-1:0]     AMP_RESET  = 18'd32768;

   // floor(x / 5) as (x * DIV5_M) >> DIV5_SHIFT, exact for any 32-bit x
   localparam logic [31:0] DIV5_M     = 32'hCCCCCCCD;
   localparam int          DIV5_SHIFT = 34;

   // lattice hash
   localparam word_type HASH_X    = 32'd1619;
   localparam word_type HASH_Y    = 32'd31337;
   localparam word_type HASH_Z    = 32'd6271;
   localparam word_type HASH_A    = 32'd15731;
   localparam word_type HASH_B    = 32'd789221;
   localparam word_type HASH_C    = 32'd1376312589;
   localparam word_type HASH_HALF = 32'd1073741824;

   // output saturation and smoothstep window
   localparam sum_type RAW_MAX    = 24'sd524287;
   localparam sum_type RAW_MIN    = -24'sd524288;
   localparam sum_type REMAP_LOW  = 24'sd19661;
   localparam sum_type REMAP_HIGH = 24'sd45875;

   // t = d * 32768 / 13107 as (d * RECIP_M) >> RECIP_SHIFT, exact for d < 26214
   localparam int             DIFF_W      = 15;
   localparam int             RECIP_W     = 31;
   localparam logic [30:0]    RECIP_M     = 31'd1342197761;
   localparam int             RECIP_SHIFT = 29;
   localparam logic [17:0]    THREE_Q16   = 18'd196608;
   localparam logic [DENS_W-1:0] ONE_Q16  = 17'd65536;

endpackage

FILE: sv/vnf_octave.sv
// ----------------------------------------------------------------------------
// vnf_octave: one octave of trilinear value noise, weighted by amplitude
// Ten register stages: scale, hash (five stages) beside the quintic fade,
// three lerp levels and the amplitude product. All stages move on adv.
// ----------------------------------------------------------------------------
module vnf_octave
   import vnf_pkg::*;
#(
   parameter int FREQ_W        = 27,
   parameter int FRACTION_BITS = 16
) (
   input  logic              clock,
   input  logic              adv,
   input  coord_type         pt_x,
   input  coord_type         pt_y,
   input  coord_type         pt_z,
   input  logic [FREQ_W-1:0] freq,
   input  logic [AMP_W-1:0]  amp,
   output contrib_type       contrib
);

   localparam int FB      = FRACTION_BITS;
   localparam int PROD_W  = 2 * FB;
   localparam int NUM_W   = 2 * FB + 4;
   localparam int INNER_W = FB + 4;
   localparam int W_W     = FB + 4;
   localparam int QP_W    = FB + INNER_W;

   coord_type pt [3];

   // stage 1: lattice index and cell fraction
   word_type          ix_ff [3], ix_in [3];
   logic [FB-1:0]     frac_ff [3], frac_in [3];
   // stage 2: hash terms, fraction square
   word_type          hx_ff, hx_in, hy_ff, hy_in, hz_ff, hz_in;
   logic [PROD_W-1:0] sq_ff [3], sq_in [3];
   logic [FB-1:0]     frac2_ff [3], frac2_in [3];
   // stage 3: mixed seed per corner, cube and fade polynomial
   word_type          n3_ff [8], n3_in [8];
   logic [PROD_W-1:0] cube_ff [3], cube_in [3];
   logic [INNER_W-1:0] inner_ff [3], inner_in [3];
   // stage 4
   word_type          n4_ff [8], nn_ff [8], nn_in [8];
   logic [QP_W-1:0]   qp_ff [3], qp_in [3];
   // stage 5
   word_type          n5_ff [8], mix_ff [8], mix_in [8];
   logic [W_W-1:0]    w5_ff [3], w5_in [3];
   // stage 6: corner values
   lattice_type       corner_ff [8], corner_in [8];
   logic [W_W-1:0]    w6_ff [3];
   // stages 7 to 10
   lattice_type       lx_ff [4], lx_in [4];
   logic [W_W-1:0]    wy7_ff, wz7_ff, wz8_ff;
   lattice_type       ly_ff [2], ly_in [2];
   lattice_type       noise_ff, noise_in;
   contrib_type       contrib_ff, contrib_in;

   assign pt[0] = pt_x;
   assign pt[1] = pt_y;
   assign pt[2] = pt_z;

   // a + floor(w * (b - a) / 2^FB)
   function automatic lattice_type blend(lattice_type a, lattice_type b,
                                         logic [W_W-1:0] w);
      logic signed [32:0]    diff;
      logic signed [W_W+33:0] p;
      diff = {b[31], b} - {a[31], a};
      p    = $signed({1'b0, w}) * diff;
      return a + lattice_type'(p >>> FB);
   endfunction

   // datapath next values
   always_comb begin
      logic signed [63:0]   s;
      word_type             hsum;
      word_type             m;
      logic [NUM_W-1:0]     num;
      logic signed [50:0]   cp;
      for (int k = 0; k < 3; k++) begin
         s           = pt[k] * $signed({1'b0, freq});
         ix_in[k]    = s[63:32];
         frac_in[k]  = s[31:32-FB];
         sq_in[k]    = frac_ff[k] * frac_ff[k];
         frac2_in[k] = frac_ff[k];
         cube_in[k]  = sq_ff[k][PROD_W-1:FB] * frac2_ff[k];
         num         = NUM_W'(6) * NUM_W'(sq_ff[k]) + (NUM_W'(10) << PROD_W)
                       - NUM_W'(15) * (NUM_W'(frac2_ff[k]) << FB);
         inner_in[k] = num[NUM_W-1:FB];
         qp_in[k]    = cube_ff[k][PROD_W-1:FB] * inner_ff[k];
         w5_in[k]    = qp_ff[k][QP_W-1:FB];
      end
      hx_in = ix_ff[0] * HASH_X;
      hy_in = ix_ff[1] * HASH_Y;
      hz_in = ix_ff[2] * HASH_Z;
      for (int k = 0; k < 8; k++) begin
         hsum = hx_ff + hy_ff + hz_ff
                + (((k & 1) != 0) ? HASH_X : 32'd0)
                + (((k & 2) != 0) ? HASH_Y : 32'd0)
                + (((k & 4) != 0) ? HASH_Z : 32'd0);
         n3_in[k]     = (hsum << 13) ^ hsum;
         nn_in[k]     = n3_ff[k] * n3_ff[k];
         mix_in[k]    = nn_ff[k] * HASH_A + HASH_B;
         m            = n5_ff[k] * mix_ff[k] + HASH_C;
         corner_in[k] = lattice_type'(HASH_HALF - {1'b0, m[30:0]});
      end
      lx_in[0] = blend(corner_ff[0], corner_ff[1], w6_ff[0]);
      lx_in[1] = blend(corner_ff[2], corner_ff[3], w6_ff[0]);
      lx_in[2] = blend(corner_ff[4], corner_ff[5], w6_ff[0]);
      lx_in[3] = blend(corner_ff[6], corner_ff[7], w6_ff[0]);
      ly_in[0] = blend(lx_ff[0], lx_ff[1], wy7_ff);
      ly_in[1] = blend(lx_ff[2], lx_ff[3], wy7_ff);
      noise_in = blend(ly_ff[0], ly_ff[1], wz8_ff);
      cp         = $signed({1'b0, amp}) * noise_ff;
      contrib_in = contrib_type'(cp >>> 30);
   end

   // advance all stages together
   always_ff @(posedge clock) begin
      if (adv) begin
         ix_ff    <= ix_in;
         frac_ff  <= frac_in;
         hx_ff    <= hx_in;
         hy_ff    <= hy_in;
         hz_ff    <= hz_in;
         sq_ff    <= sq_in;
         frac2_ff <= frac2_in;
         n3_ff    <= n3_in;
         cube_ff  <= cube_in;
         inner_ff <= inner_in;
         n4_ff    <= n3_ff;
         nn_ff    <= nn_in;
         qp_ff    <= qp_in;
         n5_ff    <= n4_ff;
         mix_ff   <= mix_in;
         w5_ff    <= w5_in;
         corner_ff <= corner_in;
         w6_ff    <= w5_ff;
         lx_ff    <= lx_in;
         wy7_ff   <= w6_ff[1];
         wz7_ff   <= w6_ff[2];
         ly_ff    <= ly_in;
         wz8_ff   <= wz7_ff;
         noise_ff <= noise_in;
         contrib_ff <= contrib_in;
      end
   end

   assign contrib = contrib_ff;

endmodule

FILE: sv/value_noise_fbm_density_core.sv
// ----------------------------------------------------------------------------
// value_noise_fbm_density_core: fractal value-noise density sampler
// Sums OCTAVES octaves of trilinear value noise at a Q16.16 point and
// returns the saturated sum and its smoothstep remap over 0.3..0.7.
//
//   channel  dir   payload                              handshake
//   req_     in    point_x, point_y, point_z            tvalid/tready
//   rsp_     out   density, raw_sum                     tvalid/tready
//   csr_     in    start frequency, start amplitude     APB, pready high
//
// One request per cycle while nothing stalls; 16 register stages (10 in the
// octave lanes, 6 for sum, saturation and remap). Octaves run in
// parallel lanes.
// All stages move together; a stall on rsp_ holds every stage and
// drops req_tready, so nothing is lost or repeated.
// After reset and after each frequency write, the per-octave frequency
// table fills one octave a cycle; req_tready stays low meanwhile.
// ----------------------------------------------------------------------------
module value_noise_fbm_density_core
   import vnf_pkg::*;
#(
   parameter int OCTAVES       = 4,
   parameter int FRACTION_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,   // point_x[31:0], point_y[63:32], point_z[95:64]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // density[16:0], raw_sum[36:17], zero[39:37]
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int FREQ_W   = FREQ_IN_W + OCTAVES - 1;
   localparam int FREQ2_W  = FREQ_W + 1;
   localparam int OIW      = (OCTAVES > 1) ? $clog2(OCTAVES) : 1;
   localparam int LANE_LAT = 10;
   localparam int NSTG     = LANE_LAT + 6;

   logic              adv;
   logic              csr_wr;
   logic [NSTG-1:0]   vld_ff, vld_in;

   logic [FREQ_W-1:0] tab_ff [OCTAVES];
   logic [FREQ_W-1:0] tab_in [OCTAVES];
   logic [AMP_W-1:0]  amp_ff, amp_in;
   logic              busy_ff, busy_in;
   logic [OIW-1:0]    oct_ff, oct_in;

   contrib_type       contrib [OCTAVES];

   sum_type           sum_ff, sum_in;
   sum_type           raw12_ff, raw12_in;
   logic              lo12_ff, lo12_in, hi12_ff, hi12_in;
   logic [DIFF_W-1:0] d12_ff, d12_in;
   sum_type           raw13_ff;
   logic              lo13_ff, hi13_ff;
   logic [DIFF_W+RECIP_W-1:0] dm13_ff, dm13_in;
   sum_type           raw14_ff;
   logic              lo14_ff, hi14_ff;
   logic [15:0]       t14_ff, t14_in;
   logic [31:0]       tt14_ff, tt14_in;
   sum_type           raw15_ff;
   logic              lo15_ff, hi15_ff;
   logic [33:0]       p15_ff, p15_in;
   logic [RAW_W-1:0]  raw16_ff, raw16_in;
   logic [DENS_W-1:0] dens16_ff, dens16_in;

   // stream control: one global advance
   assign adv        = !vld_ff[NSTG-1] || rsp_tready;
   assign req_tready = adv && !busy_ff;
   assign vld_in     = {vld_ff[NSTG-2:0], req_tvalid && req_tready};
   assign rsp_tvalid = vld_ff[NSTG-1];
   assign rsp_tdata  = {3'b000, raw16_ff, dens16_ff};

   // register port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == REG_AMP) ? {14'd0, amp_ff}
                                                 : {8'd0, tab_ff[0][FREQ_IN_W-1:0]};

   // frequency table: tab[o+1] = floor(9 * tab[o] / 5) = 2 * tab[o] - ceil(tab[o] / 5),
   // one octave a cycle
   always_comb begin
      logic [31:0]        fp4;
      logic [63:0]        qp;
      logic [FREQ2_W-1:0] twice;
      logic [FREQ_W-1:0]  step;
      tab_in  = tab_ff;
      amp_in  = amp_ff;
      busy_in = busy_ff;
      oct_in  = oct_ff;
      fp4     = 32'(tab_ff[oct_ff]) + 32'd4;
      qp      = fp4 * DIV5_M;
      twice   = {tab_ff[oct_ff], 1'b0};
      step    = FREQ_W'(twice - FREQ2_W'(qp[63:DIV5_SHIFT]));
      if (busy_ff) begin
         for (int i = 1; i < OCTAVES; i++) begin
            if (OIW'(i - 1) == oct_ff) begin
               tab_in[i] = step;
            end
         end
         oct_in = oct_ff + 1'b1;
         if (oct_ff == OIW'(OCTAVES - 2)) begin
            busy_in = 1'b0;
         end
      end
      if (csr_wr) begin
         case (csr_paddr[2])
            REG_AMP: begin
               amp_in = csr_pwdata[AMP_W-1:0];
            end
            REG_FREQ: begin
               tab_in[0] = FREQ_W'(csr_pwdata[FREQ_IN_W-1:0]);
               busy_in   = (OCTAVES > 1);
               oct_in    = '0;
            end
            default: begin
               amp_in = amp_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tab_ff[0] <= FREQ_W'(FREQ_RESET);
         amp_ff    <= AMP_RESET;
         busy_ff   <= (OCTAVES > 1);
         oct_ff    <= '0;
         vld_ff    <= '0;
      end else begin
         tab_ff[0] <= tab_in[0];
         amp_ff    <= amp_in;
         busy_ff   <= busy_in;
         oct_ff    <= oct_in;
         if (adv) begin
            vld_ff <= vld_in;
         end
      end
      for (int i = 1; i < OCTAVES; i++) begin
         tab_ff[i] <= tab_in[i];
      end
   end

   // octave lanes
   for (genvar o = 0; o < OCTAVES; o++) begin : g_oct
      vnf_octave #(
         .FREQ_W        (FREQ_W),
         .FRACTION_BITS (FRACTION_BITS)
      ) u_oct (
         .clock   (clock),
         .adv     (adv),
         .pt_x    (req_tdata[31:0]),
         .pt_y    (req_tdata[63:32]),
         .pt_z    (req_tdata[95:64]),
         .freq    (tab_ff[o]),
         .amp     (AMP_W'(amp_ff >> o)),
         .contrib (contrib[o])
      );
   end

   // sum, saturate and smoothstep remap
   always_comb begin
      sum_type dsum;
      sum_in = '0;
      for (int o = 0; o < OCTAVES; o++) begin
         sum_in = sum_in + SUM_W'(contrib[o]);
      end
      if (sum_ff > RAW_MAX) begin
         raw12_in = RAW_MAX;
      end else if (sum_ff < RAW_MIN) begin
         raw12_in = RAW_MIN;
      end else begin
         raw12_in = sum_ff;
      end
      lo12_in   = (sum_ff <= REMAP_LOW);
      hi12_in   = (sum_ff >= REMAP_HIGH);
      dsum      = sum_ff - REMAP_LOW;
      d12_in    = dsum[DIFF_W-1:0];
      dm13_in   = d12_ff * RECIP_M;
      t14_in    = dm13_ff[RECIP_SHIFT+15:RECIP_SHIFT];
      tt14_in   = t14_in * t14_in;
      p15_in    = tt14_ff[31:16] * (THREE_Q16 - {1'b0, t14_ff, 1'b0});
      raw16_in  = raw15_ff[RAW_W-1:0];
      if (lo15_ff) begin
         dens16_in = '0;
      end else if (hi15_ff) begin
         dens16_in = ONE_Q16;
      end else begin
         dens16_in = p15_ff[32:16];
      end
   end

   // remap stages hold on stall
   always_ff @(posedge clock) begin
      if (adv) begin
         sum_ff    <= sum_in;
         raw12_ff  <= raw12_in;
         lo12_ff   <= lo12_in;
         hi12_ff   <= hi12_in;
         d12_ff    <= d12_in;
         raw13_ff  <= raw12_ff;
         lo13_ff   <= lo12_ff;
         hi13_ff   <= hi12_ff;
         dm13_ff   <= dm13_in;
         raw14_ff  <= raw13_ff;
         lo14_ff   <= lo13_ff;
         hi14_ff   <= hi13_ff;
         t14_ff    <= t14_in;
         tt14_ff   <= tt14_in;
         raw15_ff  <= raw14_ff;
         lo15_ff   <= lo14_ff;
         hi15_ff   <= hi14_ff;
         p15_ff    <= p15_in;
         raw16_ff  <= raw16_in;
         dens16_ff <= dens16_in;
      end
   end

endmodule

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for value_noise_fbm_density_core
// Drives Q16.16 points through the request channel, predicts the octave sum
// and its smoothstep remap for each accepted request, and compares every
// response against the oldest prediction. Runs several register settings
// and idle/stall phases, including a long response hold-off.
// ----------------------------------------------------------------------------
module tb;
   import vnf_pkg::*;

   localparam int NUM_OCT   = 4;
   localparam int FRAC      = 16;
   localparam int LATENCY   = 16;
   localparam int TABLE_CYC = NUM_OCT - 1;
   localparam longint CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [19:0] raw_sum;
      logic [16:0] density;
   } density_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // predictor copy of the registers
   logic [23:0] cur_freq;
   logic [17:0] cur_amp;

   density_type expected_densities[$];
   int          send_idle_pct;
   int          recv_stall_pct;
   bit          hold_off;
   int          mismatches;
   longint      cycles;

   value_noise_fbm_density_core dut (.*);

   always #5 clock = ~clock;

   // hash one lattice corner into Q2.30
   function automatic longint corner_value(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      logic [31:0] n;
      logic [31:0] m;
      n = x * HASH_X + y * HASH_Y + z * HASH_Z;
      n = (n << 13) ^ n;
      m = (n * (n * n * HASH_A + HASH_B) + HASH_C) & 32'h7fffffff;
      return longint'(1073741824) - longint'(m);
   endfunction

   function automatic longint fade_weight(longint f);
      longint t2, t3, num;
      t2 = (f * f) >>> FRAC;
      t3 = (t2 * f) >>> FRAC;
      num = 6 * f * f + 10 * (longint'(1) << (2 * FRAC)) - 15 * f * (longint'(1) << FRAC);
      return (t3 * (num >>> FRAC)) >>> FRAC;
   endfunction

   function automatic longint mix(longint a, longint b, longint w);
      return a + ((w * (b - a)) >>> FRAC);
   endfunction

   function automatic longint octave_noise(longint pt[3], longint freq);
      logic [31:0] ix[3];
      longint      w[3];
      longint      c[8];
      longint      s;
      for (int k = 0; k < 3; k++) begin
         s = pt[k] * freq;
         ix[k] = s[63:32];
         w[k] = fade_weight(longint'(s[31:32-FRAC]));
      end
      for (int k = 0; k < 8; k++)
         c[k] = corner_value(ix[0] + 32'(k & 1), ix[1] + 32'((k >> 1) & 1),
                             ix[2] + 32'((k >> 2) & 1));
      return mix(mix(mix(c[0], c[1], w[0]), mix(c[2], c[3], w[0]), w[1]),
                 mix(mix(c[4], c[5], w[0]), mix(c[6], c[7], w[0]), w[1]), w[2]);
   endfunction

   function automatic density_type predict_density(logic [95:0] data);
      longint      pt[3];
      longint      freq, amp, total, clipped, t, t2, dens;
      density_type r;
      pt[0] = longint'($signed(data[31:0]));
      pt[1] = longint'($signed(data[63:32]));
      pt[2] = longint'($signed(data[95:64]));
      freq = cur_freq;
      amp = cur_amp;
      total = 0;
      for (int o = 0; o < NUM_OCT; o++) begin
         total += (amp * octave_noise(pt, freq)) >>> 30;
         freq = (freq * 9) / 5;
         amp = amp >> 1;
      end
      clipped = total > 524287 ? 524287 : (total < -524288 ? -524288 : total);
      if (total <= 19661) dens = 0;
      else if (total >= 45875) dens = 65536;
      else begin
         t = ((total - 19661) << 16) / 26214;
         t2 = (t * t) >> 16;
         dens = (t2 * (3 * 65536 - 2 * t)) >> 16;
      end
      r.density = dens[16:0];
      r.raw_sum = clipped[19:0];
      return r;
   endfunction

   // count cycles and stop a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // drive response ready and check each accepted response
   always @(posedge clock) begin
      density_type want;
      density_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[36:0];
         if (expected_densities.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h", got);
         end else begin
            want = expected_densities.pop_front();
            if (got.density !== want.density || got.raw_sum !== want.raw_sum
                || rsp_tdata[39:37] !== 3'b0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: density exp %0d got %0d, raw_sum exp %h got %h",
                           want.density, got.density, want.raw_sum, got.raw_sum);
            end
         end
      end
      rsp_tready <= !reset && !hold_off && ($urandom_range(99) >= recv_stall_pct);
   end

   // write one register over the APB port; the caller releases the bus
   task automatic write_reg(logic idx, logic [31:0] value);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_penable <= 1'b0;
      csr_paddr <= {idx, 2'b00}; csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (idx == REG_FREQ) cur_freq = value[23:0];
      else cur_amp = value[17:0];
   endtask

   // offer one request, predict its response on acceptance
   task automatic send_point(logic [95:0] data);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= data;
      do @(posedge clock); while (!req_tready);
      expected_densities.push_back(predict_density(data));
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_densities.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic configure(logic [31:0] freq, logic [31:0] amp);
      drain();
      write_reg(REG_FREQ, freq);
      write_reg(REG_AMP, amp);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      // frequency table refill; request handshake waits it out anyway
      repeat (2) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(4))
         0: return $urandom();
         1: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
         2: return {$urandom_range(1) ? 16'hffff : 16'h0000, 16'($urandom())};
         default: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
      endcase
   endfunction

   task automatic random_points(int count);
      for (int i = 0; i < count; i++)
         send_point({rand_coord(), rand_coord(), rand_coord()});
   endtask

   task automatic test_directed_points();
      send_idle_pct = 0; recv_stall_pct = 0;
      send_point('0);
      send_point({3{32'h7fffffff}});
      send_point({3{32'h80000000}});
      send_point({3{32'hffffffff}});
      send_point({32'h00008000, 32'h00010000, 32'hffff8000});
      send_point({32'h80000000, 32'h7fffffff, 32'h00000001});
      send_point({32'h55555555, 32'haaaaaaaa, 32'h0000ffff});
   endtask

   task automatic test_register_extremes();
      // largest register settings give the widest octave sum
      configure(32'hffffffff, 32'hffffffff);
      send_point('0);
      send_point({3{32'h7fffffff}});
      send_point({3{32'h12345678}});
      send_point({3{32'hfedcba98}});
      configure(32'h0, 32'h0);
      send_point({3{32'h01234567}});
      send_point({3{32'h80000000}});
      configure(32'h00010000, 32'h0003ffff);
      for (int i = 0; i < 8; i++) send_point({$urandom(), $urandom(), $urandom()});
   endtask

   task automatic test_idle_phases();
      int freqs[4] = '{65536, 16777215, 1, 300000};
      int amps[4]  = '{32768, 262143, 0, 90000};
      int idle[4]  = '{0, 76, 0, 27};
      int stall[4] = '{0, 0, 76, 27};
      for (int p = 0; p < 4; p++) begin
         configure(freqs[p], amps[p]);
         send_idle_pct = idle[p]; recv_stall_pct = stall[p];
         random_points(250);
      end
   endtask

   task automatic test_backpressure();
      configure(32'h00010000, 32'h00008000);
      send_idle_pct = 0; recv_stall_pct = 0;
      fork
         begin
            hold_off = 1'b1;
            repeat (300) @(posedge clock);
            hold_off = 1'b0;
         end
         random_points(100);
      join
   endtask

   initial begin
      cycles = 0;
      mismatches = 0;
      hold_off = 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      cur_freq = FREQ_RESET;
      cur_amp = AMP_RESET;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_directed_points();
      test_register_extremes();
      test_idle_phases();
      test_backpressure();
      drain();
      repeat (TABLE_CYC) @(posedge clock);
      if (mismatches == 0 && expected_densities.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
